// File: src/adnu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adnu_pkg
// Shared types and constants of the advertising data name and UUID filter.
// ----------------------------------------------------------------------------
package adnu_pkg;

  localparam int MAX_NAME_BYTES = 32;
  localparam int NAME_IDX_W     = $clog2(MAX_NAME_BYTES);
  localparam int NAME_LEN_W     = $clog2(MAX_NAME_BYTES + 1);
  localparam int NAME_WORDS     = MAX_NAME_BYTES / 8;

  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = 48;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_LEN_W  = 6;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [BYTE_W-1:0] AD_SHORT_NAME  = 8'h08;
  localparam logic [BYTE_W-1:0] AD_FULL_NAME   = 8'h09;
  localparam logic [BYTE_W-1:0] AD_UUID16_LIST = 8'h03;
  localparam logic [BYTE_W-1:0] HID_UUID_LO    = 8'h12;
  localparam logic [BYTE_W-1:0] HID_UUID_HI    = 8'h18;
  localparam logic [BYTE_W-1:0] MIN_STRUCT_LEN = 8'd2;
  localparam logic [BYTE_W-1:0] MIN_UUID_LEN   = 8'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NAME_LO  = 3'd0,
    CFG_NAME_MID = 3'd1,
    CFG_NAME_HI  = 3'd2,
    CFG_NAME_TOP = 3'd3,
    CFG_NAME_LEN = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [MAX_NAME_BYTES-1:0][BYTE_W-1:0] name_bytes;
    logic [NAME_LEN_W-1:0]                 cmp_len;
  } name_cfg_t;

  typedef struct packed {
    logic              name_hit;
    logic              uuid_hit;
    logic              last;
    logic              found;
    logic              stopped;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] addr_type;
  } evt_t;

  function automatic logic is_name_type(input logic [BYTE_W-1:0] t);
    return (t == AD_SHORT_NAME) || (t == AD_FULL_NAME);
  endfunction

endpackage
`default_nettype wire

// File: src/adnu_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adnu_ifs
// Valid/ready channels for payload bytes, results and register writes.
// ----------------------------------------------------------------------------
interface adnu_in_if import adnu_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first_byte;
  logic              last_byte;
  logic [ADDR_W-1:0] peer_addr;
  logic [BYTE_W-1:0] peer_addr_type;

  modport source(output valid, data_byte, first_byte, last_byte, peer_addr,
                 peer_addr_type, input ready);
  modport sink(input valid, data_byte, first_byte, last_byte, peer_addr,
               peer_addr_type, output ready);
endinterface

interface adnu_out_if;
  logic valid;
  logic ready;
  logic name_found;
  logic bond_request;
  logic parse_stopped;

  modport source(output valid, name_found, bond_request, parse_stopped, input ready);
  modport sink(input valid, name_found, bond_request, parse_stopped, output ready);
endinterface

interface adnu_cfg_if import adnu_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source(output valid, reg_index, wdata, input ready);
  modport sink(input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

// File: src/adnu_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adnu_cfg
// Target name registers and the derived name compare length.
// ----------------------------------------------------------------------------
module adnu_cfg import adnu_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  adnu_cfg_if.sink        cfg_ch,
  output name_cfg_t       name_cfg
);

  logic [NAME_WORDS-1:0][CFG_DATA_W-1:0] name_r;
  logic [CFG_LEN_W-1:0]                  len_r;
  logic [NAME_LEN_W-1:0]                 len_sat;
  logic [NAME_LEN_W-1:0]                 zero_len;
  logic                                  zero_seen;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_r <= '0;
      len_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        CFG_NAME_LO:  name_r[0] <= cfg_ch.wdata;
        CFG_NAME_MID: name_r[1] <= cfg_ch.wdata;
        CFG_NAME_HI:  name_r[2] <= cfg_ch.wdata;
        CFG_NAME_TOP: name_r[3] <= cfg_ch.wdata;
        CFG_NAME_LEN: len_r     <= cfg_ch.wdata[CFG_LEN_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    len_sat = (len_r > CFG_LEN_W'(MAX_NAME_BYTES)) ? NAME_LEN_W'(MAX_NAME_BYTES)
                                                   : NAME_LEN_W'(len_r);
    zero_seen = 1'b0;
    zero_len  = '0;
    for (int i = MAX_NAME_BYTES - 1; i >= 0; i--) begin
      if (name_r[i / 8][(i % 8) * 8 +: 8] == '0) begin
        zero_seen = 1'b1;
        zero_len  = NAME_LEN_W'(i + 1);
      end
    end
    for (int i = 0; i < MAX_NAME_BYTES; i++) begin
      name_cfg.name_bytes[i] = name_r[i / 8][(i % 8) * 8 +: 8];
    end
    name_cfg.cmp_len = (zero_seen && zero_len < len_sat) ? zero_len : len_sat;
  end

endmodule
`default_nettype wire

// File: src/adnu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adnu_front
// Walks the length-type-value structures and emits completion events.
// ----------------------------------------------------------------------------
module adnu_front import adnu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  adnu_in_if.sink   in_ch,
  input  name_cfg_t name_cfg,
  input  logic      q_full,
  output logic      q_push,
  output evt_t      q_data
);

  logic [BYTE_W-1:0] off_r, off_nxt, len_r, len_nxt, typ_r, typ_nxt;
  logic              neq_r, neq_nxt, uok_r, uok_nxt;
  logic              stop_r, stop_nxt, found_r, found_nxt;

  logic [BYTE_W-1:0] off, len, typ, d, b;
  logic              neq, uok, stop, found, name_hit, uuid_hit, accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.data_byte;

  always_comb begin
    off = off_r; len = len_r; typ = typ_r;
    neq = neq_r; uok = uok_r; stop = stop_r; found = found_r;
    if (in_ch.first_byte) begin
      off = '0; len = '0; typ = '0;
      neq = 1'b1; uok = 1'b0; stop = 1'b0; found = 1'b0;
    end
    name_hit = 1'b0;
    uuid_hit = 1'b0;
    d        = off - 8'd2;
    if (!stop) begin
      if (off == '0) begin
        if (b < MIN_STRUCT_LEN) begin
          stop = 1'b1;
        end else begin
          len = b;
          off = 8'd1;
        end
      end else begin
        if (off == 8'd1) begin
          typ = b;
          neq = 1'b1;
          uok = 1'b0;
        end else if (is_name_type(typ)) begin
          if (d < BYTE_W'(name_cfg.cmp_len) &&
              b != name_cfg.name_bytes[d[NAME_IDX_W-1:0]]) begin
            neq = 1'b0;
          end
        end else if (typ == AD_UUID16_LIST) begin
          if (d == 8'd0) begin
            uok = (b == HID_UUID_LO);
          end else if (d == 8'd1) begin
            uok = uok && (b == HID_UUID_HI);
          end
        end
        if (off == len) begin
          if (is_name_type(typ)) begin
            if (neq && (len - 8'd1) >= BYTE_W'(name_cfg.cmp_len)) begin
              found    = 1'b1;
              name_hit = 1'b1;
            end
          end else if (typ == AD_UUID16_LIST) begin
            if (uok && len >= MIN_UUID_LEN) begin
              uuid_hit = 1'b1;
            end
          end
          off = '0;
        end else begin
          off = off + 8'd1;
        end
      end
    end

    q_data.name_hit  = name_hit;
    q_data.uuid_hit  = uuid_hit;
    q_data.last      = in_ch.last_byte;
    q_data.found     = found;
    q_data.stopped   = stop || (off != '0);
    q_data.addr      = in_ch.peer_addr;
    q_data.addr_type = in_ch.peer_addr_type;
    q_push = accept && (name_hit || uuid_hit || in_ch.last_byte);

    off_nxt = off; len_nxt = len; typ_nxt = typ;
    neq_nxt = neq; uok_nxt = uok; stop_nxt = stop; found_nxt = found;
    if (in_ch.last_byte) begin
      off_nxt = '0; len_nxt = '0; typ_nxt = '0;
      neq_nxt = 1'b1; uok_nxt = 1'b0; stop_nxt = 1'b0; found_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      len_r   <= '0;
      typ_r   <= '0;
      neq_r   <= 1'b1;
      uok_r   <= 1'b0;
      stop_r  <= 1'b0;
      found_r <= 1'b0;
    end else if (accept) begin
      off_r   <= off_nxt;
      len_r   <= len_nxt;
      typ_r   <= typ_nxt;
      neq_r   <= neq_nxt;
      uok_r   <= uok_nxt;
      stop_r  <= stop_nxt;
      found_r <= found_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/adnu_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adnu_fifo
// Short first-word-fall-through queue of events between front and back.
// ----------------------------------------------------------------------------
module adnu_fifo import adnu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  evt_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output evt_t head
);

  evt_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop)) else $error("event queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("event queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CNT_W'(FIFO_DEPTH)) else $error("event queue count out of range");
`endif

endmodule
`default_nettype wire

// File: src/adnu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adnu_back
// Applies bond and address effects and registers the per-report result.
// ----------------------------------------------------------------------------
module adnu_back import adnu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  evt_t       q_head,
  output logic       q_pop,
  adnu_out_if.source out_ch
);

  logic              bond_r, bond_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [BYTE_W-1:0] atype_r;
  logic              out_valid_r, out_valid_nxt;
  logic              found_r, stopped_r, bond_out_r;
  logic              slot_free;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign q_pop     = !q_empty && (!q_head.last || slot_free);

  always_comb begin
    bond_nxt = bond_r;
    if (q_head.name_hit && (addr_r != q_head.addr || atype_r != q_head.addr_type)) begin
      bond_nxt = 1'b0;
    end
    if (q_head.uuid_hit) begin
      bond_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (q_pop && q_head.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bond_r      <= 1'b0;
      addr_r      <= '0;
      atype_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        bond_r <= bond_nxt;
        if (q_head.uuid_hit) begin
          addr_r  <= q_head.addr;
          atype_r <= q_head.addr_type;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.last) begin
      found_r    <= q_head.found;
      stopped_r  <= q_head.stopped;
      bond_out_r <= bond_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.name_found    = found_r;
  assign out_ch.bond_request  = bond_out_r;
  assign out_ch.parse_stopped = stopped_r;

`ifndef SYNTHESIS
  a_uuid_sets_bond: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_head.uuid_hit |=> bond_r) else $error("HID list did not set bond");
  a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_head.last |=> out_valid_r) else $error("report end gave no word");
  a_result_bond: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_head.last |=> bond_out_r == bond_r) else $error("result bond mismatch");
`endif

endmodule
`default_nettype wire

// File: src/adv_data_name_uuid_filter_core.sv
`default_nettype none
// A report's result word passes from the front end through the event queue to the
// output register, and is held there until out_ch.ready takes it.
// Throughput: one payload byte per cycle. The input stalls only while a result word
// waits on out_ch.ready in the output register and two events are queued behind it.
// Reset: synchronous, active low; clears the parse state, bond flag, stored
// address and the target name registers. No clearing pass is needed.
// ----------------------------------------------------------------------------
// adv_data_name_uuid_filter_core
// Advertising data parser that flags a target name and HID service bonding.
// ----------------------------------------------------------------------------
module adv_data_name_uuid_filter_core import adnu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  adnu_in_if.sink    in_ch,
  adnu_out_if.source out_ch,
  adnu_cfg_if.sink   cfg_ch
);

  name_cfg_t name_cfg;
  logic      q_push, q_full, q_pop, q_empty;
  evt_t      q_data, q_head;

  adnu_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_ch   (cfg_ch),
    .name_cfg (name_cfg)
  );

  adnu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .name_cfg (name_cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  adnu_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  adnu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// File: tb/adnu_filter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adnu_filter_checker
// Watches the payload, result and register channels of the advertising data
// filter. It keeps its own copy of the parse state, the bond flag and the
// target name, predicts the result word of each report, and compares every
// result word with the oldest prediction.
// ----------------------------------------------------------------------------
module adnu_filter_checker import adnu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  adnu_in_if          in_mon,
  adnu_out_if         out_mon,
  adnu_cfg_if         cfg_mon,
  output int unsigned mismatch_count,
  output int unsigned pending_reports,
  output int unsigned reports_checked,
  output int unsigned names_found,
  output int unsigned bonds_seen,
  output int unsigned stops_seen
);

  typedef struct packed {
    logic name_found;
    logic bond_request;
    logic parse_stopped;
  } report_word_t;

  report_word_t expected_reports[$];

  logic [NAME_WORDS-1:0][CFG_DATA_W-1:0] tgt_words;
  logic [CFG_LEN_W-1:0]                  tgt_len;

  logic [BYTE_W-1:0] pos_in_struct;
  logic [BYTE_W-1:0] struct_len;
  logic [BYTE_W-1:0] struct_kind;
  logic              name_ok;
  logic              hid_ok;
  logic              parse_halted;
  logic              name_hit;
  logic              bond_flag;
  logic [ADDR_W-1:0] bond_addr;
  logic [BYTE_W-1:0] bond_addr_type;

  function automatic logic [BYTE_W-1:0] tgt_byte(input int idx);
    return tgt_words[idx / 8][8 * (idx % 8) +: 8];
  endfunction

  // The compare stops after the first zero byte of the target, which must
  // itself match.
  function automatic int name_cmp_len();
    int n;
    n = (int'(tgt_len) > MAX_NAME_BYTES) ? MAX_NAME_BYTES : int'(tgt_len);
    for (int i = 0; i < n; i++) begin
      if (tgt_byte(i) == '0) return i + 1;
    end
    return n;
  endfunction

  task automatic restart_parse();
    pos_in_struct = '0;
    struct_len    = '0;
    struct_kind   = '0;
    name_ok       = 1'b1;
    hid_ok        = 1'b0;
    parse_halted  = 1'b0;
    name_hit      = 1'b0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic first,
                            input logic last, input logic [ADDR_W-1:0] addr,
                            input logic [BYTE_W-1:0] atype);
    int clen;
    int d;
    clen = name_cmp_len();
    if (first) restart_parse();
    if (!parse_halted) begin
      if (pos_in_struct == '0) begin
        if (b < MIN_STRUCT_LEN) begin
          parse_halted = 1'b1;
        end else begin
          struct_len    = b;
          pos_in_struct = 8'd1;
        end
      end else begin
        if (pos_in_struct == 8'd1) begin
          struct_kind = b;
          name_ok     = 1'b1;
          hid_ok      = 1'b0;
        end else begin
          d = int'(pos_in_struct) - 2;
          if (struct_kind == AD_SHORT_NAME || struct_kind == AD_FULL_NAME) begin
            if (d < clen && b != tgt_byte(d)) name_ok = 1'b0;
          end else if (struct_kind == AD_UUID16_LIST) begin
            if (d == 0) hid_ok = (b == HID_UUID_LO);
            else if (d == 1) hid_ok = hid_ok && (b == HID_UUID_HI);
          end
        end
        if (pos_in_struct == struct_len) begin
          if (struct_kind == AD_SHORT_NAME || struct_kind == AD_FULL_NAME) begin
            if (name_ok && int'(struct_len) - 1 >= clen) begin
              name_hit = 1'b1;
              if (bond_addr != addr || bond_addr_type != atype) bond_flag = 1'b0;
            end
          end else if (struct_kind == AD_UUID16_LIST) begin
            if (hid_ok && struct_len >= MIN_UUID_LEN) begin
              bond_flag      = 1'b1;
              bond_addr      = addr;
              bond_addr_type = atype;
            end
          end
          pos_in_struct = '0;
        end else begin
          pos_in_struct++;
        end
      end
    end
    if (last) begin
      if (!parse_halted && pos_in_struct != '0) parse_halted = 1'b1;
      expected_reports.push_back('{name_hit, bond_flag, parse_halted});
      restart_parse();
    end
  endtask

  always @(posedge clk) begin : watch
    report_word_t seen;
    report_word_t want;
    if (!rst_n) begin
      expected_reports.delete();
      tgt_words       = '0;
      tgt_len         = '0;
      bond_flag       = 1'b0;
      bond_addr       = '0;
      bond_addr_type  = '0;
      mismatch_count  = 0;
      reports_checked = 0;
      names_found     = 0;
      bonds_seen      = 0;
      stops_seen      = 0;
      restart_parse();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_t'(cfg_mon.reg_index))
          CFG_NAME_LO:  tgt_words[0] = cfg_mon.wdata;
          CFG_NAME_MID: tgt_words[1] = cfg_mon.wdata;
          CFG_NAME_HI:  tgt_words[2] = cfg_mon.wdata;
          CFG_NAME_TOP: tgt_words[3] = cfg_mon.wdata;
          CFG_NAME_LEN: tgt_len = cfg_mon.wdata[CFG_LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        parse_byte(in_mon.data_byte, in_mon.first_byte, in_mon.last_byte,
                   in_mon.peer_addr, in_mon.peer_addr_type);
      end
      if (out_mon.valid && out_mon.ready) begin
        seen = '{out_mon.name_found, out_mon.bond_request, out_mon.parse_stopped};
        if (expected_reports.size() == 0) begin
          report_mismatch($sformatf("result word %b with no report pending", seen));
        end else begin
          want = expected_reports.pop_front();
          reports_checked++;
          if (seen.name_found !== want.name_found)
            report_mismatch($sformatf("name_found %b, expected %b",
                                      seen.name_found, want.name_found));
          if (seen.bond_request !== want.bond_request)
            report_mismatch($sformatf("bond_request %b, expected %b",
                                      seen.bond_request, want.bond_request));
          if (seen.parse_stopped !== want.parse_stopped)
            report_mismatch($sformatf("parse_stopped %b, expected %b",
                                      seen.parse_stopped, want.parse_stopped));
          names_found += want.name_found;
          bonds_seen  += want.bond_request;
          stops_seen  += want.parse_stopped;
        end
      end
    end
    pending_reports = expected_reports.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives advertising reports into the name and UUID filter. A short directed
// set of reports comes first, then random reports built mostly from valid
// name, UUID list and other structures, with bad lengths, cut-off endings and
// stray report starts mixed in. Phases change the target name and the amount
// of idling on both channels; the checker decides on every result word.
// ----------------------------------------------------------------------------
module testbench;
  import adnu_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_BYTES = 205;

  logic clk;
  logic rst_n;

  adnu_in_if  in_ch();
  adnu_out_if out_ch();
  adnu_cfg_if cfg_ch();

  int unsigned mismatch_count;
  int unsigned pending_reports;
  int unsigned reports_checked;
  int unsigned names_found;
  int unsigned bonds_seen;
  int unsigned stops_seen;

  int sender_idle_pct;
  int recv_stall_pct;
  int bytes_sent;

  logic [NAME_WORDS-1:0][CFG_DATA_W-1:0] name_words;
  logic [CFG_LEN_W-1:0]                  name_len;
  logic [BYTE_W-1:0]                     payload[$];
  logic [ADDR_W-1:0]                     addr_pool[3];
  logic [BYTE_W-1:0]                     type_pool[3];

  adv_data_name_uuid_filter_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  adnu_filter_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_mon         (cfg_ch),
    .mismatch_count  (mismatch_count),
    .pending_reports (pending_reports),
    .reports_checked (reports_checked),
    .names_found     (names_found),
    .bonds_seen      (bonds_seen),
    .stops_seen      (stops_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[adv_data_name_uuid_filter_core] ERROR");
    $finish;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic first,
                           input logic last, input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] atype);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b;
    in_ch.first_byte     <= first;
    in_ch.last_byte      <= last;
    in_ch.peer_addr      <= addr;
    in_ch.peer_addr_type <= atype;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_reports != 0) @(negedge clk);
  endtask

  task automatic load_target(input logic [NAME_WORDS-1:0][CFG_DATA_W-1:0] words,
                             input logic [CFG_LEN_W-1:0] len);
    wait_drained();
    repeat (8) @(negedge clk);
    name_words = words;
    name_len   = len;
    write_reg(CFG_NAME_LO, words[0]);
    write_reg(CFG_NAME_MID, words[1]);
    write_reg(CFG_NAME_HI, words[2]);
    write_reg(CFG_NAME_TOP, words[3]);
    write_reg(CFG_NAME_LEN, CFG_DATA_W'(len));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_report(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] atype,
                             input bit mark_first, input bit stray_starts);
    logic first;
    for (int i = 0; i < payload.size(); i++) begin
      first = (i == 0) ? mark_first : (stray_starts && $urandom_range(39) == 0);
      push_byte(payload[i], first, i == payload.size() - 1, addr, atype);
    end
  endtask

  function automatic logic [BYTE_W-1:0] name_byte(input int j);
    return name_words[j / 8][8 * (j % 8) +: 8];
  endfunction

  task automatic add_name_struct();
    int eff;
    int k;
    int mode;
    int bad;
    eff = (int'(name_len) > MAX_NAME_BYTES) ? MAX_NAME_BYTES : int'(name_len);
    k = ($urandom_range(3) == 0) ? int'($urandom_range(40)) : eff + int'($urandom_range(2)) - 1;
    if (k < 0) k = 0;
    mode = $urandom_range(3);
    bad  = $urandom_range(k > 0 ? k - 1 : 0);
    payload.push_back(8'(k + 1));
    payload.push_back($urandom_range(1) ? AD_FULL_NAME : AD_SHORT_NAME);
    for (int j = 0; j < k; j++) begin
      if (mode == 3 || j >= MAX_NAME_BYTES) payload.push_back(8'($urandom));
      else if (mode == 2 && j == bad) payload.push_back(name_byte(j) ^ (8'd1 << $urandom_range(7)));
      else payload.push_back(name_byte(j));
    end
  endtask

  task automatic add_uuid_struct();
    int k;
    k = ($urandom_range(3) == 0) ? int'($urandom_range(6)) : 2 * int'($urandom_range(1, 3));
    payload.push_back(8'(k + 1));
    payload.push_back(AD_UUID16_LIST);
    for (int j = 0; j < k; j++) begin
      if (j == 0 && $urandom_range(2) != 0) payload.push_back(HID_UUID_LO);
      else if (j == 1 && $urandom_range(2) != 0) payload.push_back(HID_UUID_HI);
      else payload.push_back(8'($urandom));
    end
  endtask

  task automatic add_other_struct();
    int k;
    k = $urandom_range(6);
    payload.push_back(8'(k + 1));
    payload.push_back(8'($urandom));
    repeat (k) payload.push_back(8'($urandom));
  endtask

  // Most reports end cleanly; the rest end in a bad length, a structure that
  // runs past the last byte, or a length of 255 that cannot complete.
  task automatic build_report();
    int ending;
    int cut;
    payload.delete();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(3))
        0, 1: add_name_struct();
        2: add_uuid_struct();
        default: add_other_struct();
      endcase
    end
    ending = $urandom_range(9);
    if (ending == 0) begin
      payload.push_back(8'($urandom_range(1)));
      repeat ($urandom_range(3)) payload.push_back(8'($urandom));
    end else if (ending == 1) begin
      cut = $urandom_range(1, 3);
      while (cut > 0 && payload.size() > 1) begin
        void'(payload.pop_back());
        cut--;
      end
    end else if (ending == 2) begin
      payload.push_back(8'hFF);
      repeat ($urandom_range(4)) payload.push_back(8'($urandom));
    end
  endtask

  task automatic run_random(input int n_bytes);
    int start;
    int idx;
    bit drained;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] atype;
    start   = bytes_sent;
    drained = 1'b0;
    while (bytes_sent - start < n_bytes) begin
      build_report();
      idx   = $urandom_range(3);
      addr  = (idx < 3) ? addr_pool[idx] : ADDR_W'({$urandom, $urandom});
      idx   = ($urandom_range(5) == 0) ? 3 : idx;
      atype = (idx < 3) ? type_pool[idx] : 8'($urandom);
      send_report(addr, atype, $urandom_range(7) != 0, 1'b1);
      if (!drained && bytes_sent - start >= n_bytes / 2) begin
        wait_drained();
        drained = 1'b1;
      end
    end
  endtask

  task automatic run_directed();
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    addr_a = '0;
    addr_b = '1;
    payload = '{8'h03, AD_UUID16_LIST, HID_UUID_LO, HID_UUID_HI};
    send_report(addr_a, 8'h00, 1'b1, 1'b0);
    payload = '{8'h03, AD_FULL_NAME, 8'h41, 8'h42};
    send_report(addr_a, 8'h00, 1'b1, 1'b0);
    payload = '{8'h03, AD_SHORT_NAME, 8'h41, 8'h42};
    send_report(addr_b, 8'hFF, 1'b1, 1'b0);
    payload = '{8'h00, 8'hFF};
    send_report(addr_a, 8'h00, 1'b1, 1'b0);
    payload = '{8'h02, AD_FULL_NAME, 8'h41};
    send_report(addr_a, 8'h00, 1'b1, 1'b0);
    payload = '{8'h05, AD_FULL_NAME, 8'h41, 8'h42};
    send_report(addr_a, 8'h00, 1'b1, 1'b0);
    payload = '{8'h01};
    send_report(addr_b, 8'hFF, 1'b1, 1'b0);
    payload = '{8'h02, AD_UUID16_LIST, HID_UUID_LO};
    send_report(addr_b, 8'hFF, 1'b0, 1'b0);
  endtask

  task automatic load_phase_target(input int phase);
    logic [NAME_WORDS-1:0][CFG_DATA_W-1:0] words;
    logic [CFG_LEN_W-1:0]                  len;
    for (int j = 0; j < MAX_NAME_BYTES; j++) begin
      words[j / 8][8 * (j % 8) +: 8] = 8'($urandom_range(1, 255));
    end
    case (phase)
      0: begin
        words = '0;
        words[0] = 64'h4241;
        len = 6'd2;
      end
      1: len = 6'd0;
      2: len = 6'd32;
      3: begin
        words = '1;
        len = 6'd63;
      end
      4: begin
        words[0][31:24] = 8'h00;
        len = 6'd12;
      end
      5: begin
        words = '0;
        len = 6'd5;
      end
      6: len = 6'($urandom_range(1, 8));
      default: begin
        for (int w = 0; w < NAME_WORDS; w++) words[w] = {$urandom, $urandom};
        len = 6'd32;
      end
    endcase
    load_target(words, len);
  endtask

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = '0;
    in_ch.first_byte     = 1'b0;
    in_ch.last_byte      = 1'b0;
    in_ch.peer_addr      = '0;
    in_ch.peer_addr_type = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.reg_index     = CFG_NAME_LO;
    cfg_ch.wdata         = '0;
    out_ch.ready         = 1'b0;
    rst_n                = 1'b0;
    sender_idle_pct      = 0;
    recv_stall_pct       = 0;
    bytes_sent           = 0;
    addr_pool = '{48'h0, 48'hFFFF_FFFF_FFFF, ADDR_W'({$urandom, $urandom})};
    type_pool = '{8'h00, 8'hFF, 8'($urandom)};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 65;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 65;
        end
        default: begin
          sender_idle_pct = 28;
          recv_stall_pct  = 28;
        end
      endcase
      load_phase_target(p);
      if (p == 0) run_directed();
      run_random(PHASE_BYTES);
    end

    wait_drained();
    repeat (10) @(negedge clk);

    $display("Summary: %0d payload bytes sent over %0d target and idling phases,",
             bytes_sent, PHASES);
    $display("%0d reports checked, %0d with a name match, %0d with the bond flag set, %0d stopped early.",
             reports_checked, names_found, bonds_seen, stops_seen);
    if (mismatch_count == 0) begin
      $display("[adv_data_name_uuid_filter_core] OK");
    end else begin
      $display("[adv_data_name_uuid_filter_core] ERROR");
    end
    $finish;
  end

endmodule
